// ===== design/ewzs_pkg.sv =====
// Shared types and constants for the EWMA z-score anomaly scorer.
`default_nettype none
package ewzs_pkg;
   localparam int FEATURES = 4;
   localparam int FEAT_W   = 2;
   localparam int SAMPLE_W = 24;
   localparam int Z_W      = 24;
   localparam int CNT_W    = 16;
   localparam int MEAN_W   = 33;
   localparam int VAR_W    = 48;
   localparam int ALPHA_W  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR3 = 3'd5;

   localparam logic [ALPHA_W-1:0] ALPHA_RST  = 24'd11651;
   localparam logic [CNT_W-1:0]   WARMUP_RST = 16'd60;
   localparam logic [15:0] FLOOR0_RST = 16'd256;
   localparam logic [15:0] FLOOR1_RST = 16'd128;
   localparam logic [15:0] FLOOR2_RST = 16'd512;
   localparam logic [15:0] FLOOR3_RST = 16'd128;

   typedef struct packed {
      logic [FEAT_W-1:0]          feature;
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [Z_W-1:0]    sample_z;
      logic              first_sample;
      logic              any_seen;
      logic              learning;
      logic [CNT_W-1:0]  min_count;
      logic [Z_W-1:0]    top_score;
      logic [FEAT_W-1:0] top_feature;
   } rsp_payload_type;
endpackage
`default_nettype wire

// ===== design/ewma_zscore_anomaly_scorer_core.sv =====
// Top level: EWMA mean/variance z-score scorer with a shared iterative datapath.
//
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  req     | req_valid/req_ready/req_payload | in
//  rsp     | rsp_valid/rsp_ready/rsp_payload | out
//  csr     | csr_we/csr_index/csr_wdata      | in, write only
//
// A seeding sample goes from idle straight to the final state; a later sample takes 24
// square-root steps, 34 restoring-divide steps and 10 steps on the shared 34x25 multiplier.
// One sample is in flight at a time; req_ready is high only in idle.
// A finished result waits in the output register; the sequencer holds in its
// final state while that register is occupied and rsp_ready is low.
// Synchronous reset restores the configuration and control registers and clears all feature state.
`default_nettype none
module ewma_zscore_anomaly_scorer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ewzs_pkg::req_payload_type         req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ewzs_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                              csr_we,
   input  wire logic [ewzs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ewzs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ewzs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQRT = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   // config
   logic [ALPHA_W-1:0] alpha_ff;
   logic [CNT_W-1:0]   warmup_ff;
   logic [15:0]        floor_ff [FEATURES];

   // feature state
   logic signed [MEAN_W-1:0] mean_ff  [FEATURES];
   logic [VAR_W-1:0]         var_ff   [FEATURES];
   logic [CNT_W-1:0]         count_ff [FEATURES];
   logic [Z_W-1:0]           score_ff [FEATURES];
   logic                     seen_ff  [FEATURES];

   // sequencer and datapath
   logic [2:0]              state_ff;
   logic [5:0]              step_ff;
   logic [FEAT_W-1:0]       feat_ff;
   logic                    neg_ff;
   logic [33:0]             ad_ff;
   logic [47:0]             rem_ff;
   logic [47:0]             res_ff;
   logic [47:0]             bit_ff;
   logic [23:0]             drem_ff;
   logic [33:0]             dq_ff;
   logic [Z_W-1:0]          z_ff;
   logic                    first_ff;
   logic [33:0]             incr_ff;
   logic [51:0]             t_ff;
   logic [58:0]             prod_ff;
   logic [77:0]             acc_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff;

   // shared multiplier
   logic [33:0] mul_a;
   logic [24:0] mul_b;
   logic [58:0] mul_p;
   logic [24:0] m_fac;

   assign m_fac = 25'h1000000 - {1'b0, alpha_ff};

   always_comb begin
      mul_a = ad_ff;
      mul_b = {1'b0, alpha_ff};
      unique case (step_ff[3:0])
         4'd2: begin
            mul_b = incr_ff[24:0];
         end
         4'd3: begin
            mul_b = {16'b0, incr_ff[33:25]};
         end
         4'd6: begin
            mul_a = t_ff[33:0];
            mul_b = m_fac;
         end
         4'd7: begin
            mul_a = {16'b0, t_ff[51:34]};
            mul_b = m_fac;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = {1'b0, alpha_ff};
         end
      endcase
      mul_p = 59'(mul_a) * 59'(mul_b);
   end

   // intake arithmetic
   logic signed [31:0] xq;
   logic signed [33:0] diff;
   assign xq   = {req_payload.sample, 8'b0};
   assign diff = 34'(xq) - 34'(mean_ff[req_payload.feature]);

   // square root step
   logic [48:0] sq_try;
   assign sq_try = {1'b0, res_ff} + {1'b0, bit_ff};

   // divisor after square root; res_ff and feat_ff hold still during the divide
   logic [15:0] fl_eff;
   logic [23:0] sd_in;
   assign fl_eff = (floor_ff[feat_ff] == 16'd0) ? 16'd1 : floor_ff[feat_ff];
   assign sd_in  = (res_ff[23:0] < {8'b0, fl_eff}) ? {8'b0, fl_eff} : res_ff[23:0];

   // divide step
   logic [24:0] dv_try;
   logic [24:0] dv_sub;
   assign dv_try = {drem_ff, dq_ff[33]};
   assign dv_sub = dv_try - {1'b0, sd_in};

   // incr magnitude, rounded toward minus infinity for negative diff
   logic [58:0] pm_up;
   logic [33:0] incr_in;
   assign pm_up   = prod_ff + 59'hFFFFFF;
   assign incr_in = neg_ff ? pm_up[57:24] : prod_ff[57:24];

   logic signed [33:0] mean_upd;
   assign mean_upd = neg_ff ? (34'(mean_ff[feat_ff]) - $signed(incr_in))
                            : (34'(mean_ff[feat_ff]) + $signed(incr_in));

   logic [53:0] nv_full;
   assign nv_full = acc_ff[77:24];

   // summary over stored features
   logic              any_s;
   logic [CNT_W-1:0]  min_s;
   logic [Z_W-1:0]    top_s;
   logic [FEAT_W-1:0] topi_s;
   always_comb begin
      any_s  = 1'b0;
      min_s  = '1;
      top_s  = '0;
      topi_s = '0;
      for (int i = 0; i < FEATURES; i++) begin
         if (seen_ff[i]) begin
            any_s = 1'b1;
            if (count_ff[i] < min_s) min_s = count_ff[i];
            if (score_ff[i] > top_s) begin
               top_s  = score_ff[i];
               topi_s = FEAT_W'(i);
            end
         end
      end
      if (!any_s) min_s = '0;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_RST;
         warmup_ff   <= WARMUP_RST;
         floor_ff[0] <= FLOOR0_RST;
         floor_ff[1] <= FLOOR1_RST;
         floor_ff[2] <= FLOOR2_RST;
         floor_ff[3] <= FLOOR3_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_ff    <= csr_wdata;
            CSR_WARMUP: warmup_ff   <= csr_wdata[15:0];
            CSR_FLOOR0: floor_ff[0] <= csr_wdata[15:0];
            CSR_FLOOR1: floor_ff[1] <= csr_wdata[15:0];
            CSR_FLOOR2: floor_ff[2] <= csr_wdata[15:0];
            CSR_FLOOR3: floor_ff[3] <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FEATURES; i++) begin
            mean_ff[i]  <= '0;
            var_ff[i]   <= '0;
            count_ff[i] <= '0;
            score_ff[i] <= '0;
            seen_ff[i]  <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  feat_ff <= req_payload.feature;
                  seen_ff[req_payload.feature] <= 1'b1;
                  if (count_ff[req_payload.feature] == '0) begin
                     mean_ff[req_payload.feature]  <= MEAN_W'(xq);
                     var_ff[req_payload.feature]   <= '0;
                     count_ff[req_payload.feature] <= CNT_W'(1);
                     z_ff     <= '0;
                     first_ff <= 1'b1;
                     state_ff <= ST_FIN;
                  end else begin
                     neg_ff   <= diff[33];
                     ad_ff    <= diff[33] ? 34'(-diff) : 34'(diff);
                     rem_ff   <= var_ff[req_payload.feature];
                     res_ff   <= '0;
                     bit_ff   <= 48'h4000_0000_0000;
                     first_ff <= 1'b0;
                     step_ff  <= '0;
                     state_ff <= ST_SQRT;
                  end
               end
            end
            ST_SQRT: begin
               if ({1'b0, rem_ff} >= sq_try) begin
                  rem_ff <= rem_ff - sq_try[47:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               if (step_ff == 6'd23) begin
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
               drem_ff <= '0;
               dq_ff   <= ad_ff;
            end
            ST_DIV: begin
               if (dv_try >= {1'b0, sd_in}) begin
                  drem_ff <= dv_sub[23:0];
                  dq_ff   <= {dq_ff[32:0], 1'b1};
               end else begin
                  drem_ff <= dv_try[23:0];
                  dq_ff   <= {dq_ff[32:0], 1'b0};
               end
               if (step_ff == 6'd33) begin
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            ST_MUL: begin
               if (step_ff != 6'd9) step_ff <= step_ff + 6'd1;
               unique case (step_ff[3:0])
                  4'd0: begin
                     z_ff <= (dq_ff[33:24] != '0) ? '1 : dq_ff[23:0];
                     score_ff[feat_ff] <= (dq_ff[33:24] != '0) ? '1 : dq_ff[23:0];
                  end
                  4'd1: begin
                     incr_ff          <= incr_in;
                     mean_ff[feat_ff] <= MEAN_W'(mean_upd);
                  end
                  4'd2: ;
                  4'd3: acc_ff <= 78'(prod_ff);
                  4'd4: acc_ff <= acc_ff + (78'(prod_ff) << 25);
                  4'd5: t_ff <= {4'b0, var_ff[feat_ff]} + acc_ff[67:16];
                  4'd6: ;
                  4'd7: acc_ff <= 78'(prod_ff);
                  4'd8: acc_ff <= acc_ff + (78'(prod_ff) << 34);
                  4'd9: begin
                     var_ff[feat_ff] <= (nv_full[53:48] != '0) ? '1 : nv_full[47:0];
                     if (count_ff[feat_ff] != '1)
                        count_ff[feat_ff] <= count_ff[feat_ff] + CNT_W'(1);
                     step_ff  <= '0;
                     state_ff <= ST_FIN;
                  end
                  default: state_ff <= ST_FIN;
               endcase
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.sample_z      <= z_ff;
                  rsp_ff.first_sample  <= first_ff;
                  rsp_ff.any_seen      <= any_s;
                  rsp_ff.learning      <= !any_s || (min_s < warmup_ff);
                  rsp_ff.min_count     <= min_s;
                  rsp_ff.top_score     <= top_s;
                  rsp_ff.top_feature   <= topi_s;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
